// File: src/gpte_pkg.sv
// Package with the character codes, budget constants and decimal split for the grey-map encoder.
`default_nettype none

package gpte_pkg;

  localparam int MaxBytes = 6;

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharLf    = 8'd10;

  localparam logic signed [7:0] BudgetRowStart  = 8'sd70;
  localparam logic signed [7:0] BudgetAfterWrap = 8'sd69;

  typedef logic [7:0] octet_t;

  typedef struct packed {
    logic [1:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } dec_digits_t;

  // Splits an 8-bit value into decimal digits. The hundreds come from two
  // compares; the tens from a multiply by 205/2048, exact below 100.
  function automatic dec_digits_t split_decimal(input logic [7:0] value);
    dec_digits_t d;
    logic [6:0]  rem;
    logic [14:0] prod;
    if (value >= 8'd200) begin
      d.hundreds = 2'd2;
      rem        = 7'(value - 8'd200);
    end else if (value >= 8'd100) begin
      d.hundreds = 2'd1;
      rem        = 7'(value - 8'd100);
    end else begin
      d.hundreds = 2'd0;
      rem        = value[6:0];
    end
    prod   = 15'(rem) * 15'd205;
    d.tens = prod[14:11];
    d.ones = 4'(rem - 7'(d.tens) * 7'd10);
    return d;
  endfunction

endpackage

`default_nettype wire

// File: src/greymap_pixel_text_encoder_unit.sv
// Top level of the grey-map pixel encoder: binary pass-through or decimal text with line wrapping.
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   pixel[7:0], row_end
// output    out        out_valid / out_ready out_byte[7:0], last
// config    in         cfg_wen (no wait)     cfg_wdata (ascii_mode)
//
// An accepted pixel is decoded in the same cycle into its full byte sequence,
// which is loaded into a six-entry output shift register; the first byte is
// offered on the next cycle. The output port carries one byte per cycle while
// out_ready is high; a pixel is one byte in binary mode, 2 to 6 in text mode.
// A new pixel is taken in the cycle its predecessor's final byte leaves, so
// transactions follow back to back. Reset (rst, synchronous) clears the mode
// to binary, the line budget to 70 and empties the output register. An output
// stall simply holds the shift register and, with it, the input side.

module greymap_pixel_text_encoder_unit
  import gpte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,

  input  wire logic       cfg_wen,
  input  wire logic       cfg_wdata,

  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] pixel,
  input  wire logic       row_end,

  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last
);

  // Configuration and line state.
  logic              ascii_mode;
  logic signed [7:0] line_budget;
  logic signed [7:0] line_budget_next;

  // Output shift register: entry 0 is the byte on offer, remaining counts
  // the bytes of the current transaction still to be delivered.
  octet_t     bytes [MaxBytes];
  logic [2:0] remaining;

  // Decoded sequence for the pixel at the input.
  octet_t      seq_bytes [MaxBytes];
  logic [2:0]  seq_count;
  dec_digits_t digits;
  logic        wrap;
  logic signed [7:0] budget_base;
  logic signed [7:0] cost;

  logic in_take;
  logic out_take;

  assign out_valid = (remaining != 3'd0);
  assign last      = (remaining == 3'd1);
  assign out_byte  = bytes[0];
  assign out_take  = out_valid && out_ready;

  // The input is free when nothing is held, or when the final byte of the
  // held transaction is leaving in this cycle.
  assign in_ready  = (remaining == 3'd0) || (last && out_ready);
  assign in_take   = in_valid && in_ready;

  assign digits = split_decimal(pixel);

  // A negative budget means the previous line ran long: break it first.
  assign wrap        = line_budget[7];
  assign budget_base = wrap ? BudgetAfterWrap : line_budget;

  always_comb begin
    // Digit count plus the trailing space.
    if (digits.hundreds != 2'd0) begin
      cost = 8'sd4;
    end else if (digits.tens != 4'd0) begin
      cost = 8'sd3;
    end else begin
      cost = 8'sd2;
    end
    if (row_end) begin
      line_budget_next = BudgetRowStart;
    end else begin
      line_budget_next = budget_base - cost;
    end
  end

  // Builds the byte sequence in delivery order: optional wrap line feed,
  // digits without leading zeros, a space, optional row-end line feed.
  always_comb begin
    for (int i = 0; i < MaxBytes; i++) begin
      seq_bytes[i] = '0;
    end
    seq_count = 3'd0;
    if (!ascii_mode) begin
      seq_bytes[0] = pixel;
      seq_count    = 3'd1;
    end else begin
      if (wrap) begin
        seq_bytes[seq_count] = CharLf;
        seq_count            = seq_count + 3'd1;
      end
      if (digits.hundreds != 2'd0) begin
        seq_bytes[seq_count] = CharZero + {6'd0, digits.hundreds};
        seq_count            = seq_count + 3'd1;
      end
      if (digits.hundreds != 2'd0 || digits.tens != 4'd0) begin
        seq_bytes[seq_count] = CharZero + {4'd0, digits.tens};
        seq_count            = seq_count + 3'd1;
      end
      seq_bytes[seq_count] = CharZero + {4'd0, digits.ones};
      seq_count            = seq_count + 3'd1;
      seq_bytes[seq_count] = CharSpace;
      seq_count            = seq_count + 3'd1;
      if (row_end) begin
        seq_bytes[seq_count] = CharLf;
        seq_count            = seq_count + 3'd1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_mode  <= 1'b0;
      line_budget <= BudgetRowStart;
      remaining   <= 3'd0;
    end else begin
      if (cfg_wen) begin
        ascii_mode <= cfg_wdata;
      end
      if (in_take) begin
        remaining <= seq_count;
        // In binary mode the budget is left exactly as it was.
        if (ascii_mode) begin
          line_budget <= line_budget_next;
        end
      end else if (out_take) begin
        remaining <= remaining - 3'd1;
      end
    end
  end

  // Payload: loaded on a new transaction, shifted one byte per delivered byte.
  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < MaxBytes; i++) begin
        bytes[i] <= seq_bytes[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < MaxBytes - 1; i++) begin
        bytes[i] <= bytes[i + 1];
      end
      bytes[MaxBytes - 1] <= '0;
    end
  end

endmodule

`default_nettype wire

// File: src/gpte_checker.sv
// Port-level checker for the grey-map pixel encoder, with its bind statement.
`default_nettype none

module gpte_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last
);

  // A stalled output byte holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("output transaction changed while stalled");

  // With nothing on offer the input side must be open.
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready while output is empty");

  // While bytes are pending, input is taken only as the final byte leaves.
  a_ready_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_ready |-> out_ready && last)
    else $error("input accepted while earlier bytes still pending");

  // Every accepted pixel produces output on the next cycle.
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted pixel produced no output");

  // A non-final byte is always followed by more bytes.
  a_more_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("byte sequence ended without a final byte");

endmodule

bind greymap_pixel_text_encoder_unit gpte_checker u_gpte_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .last      (last)
);

`default_nettype wire
